>>> design/kss_pkg.sv
`default_nettype none

package kss_pkg;

	// one input transaction
	typedef struct packed {
		logic       mode;
		logic [3:0] col_levels;
	} item_t;

	// one result transaction
	typedef struct packed {
		logic [3:0] row_drive;
		logic       key_valid;
		logic [3:0] key_code;
		logic       serial_valid;
		logic       serial_bit;
		logic       latch_pulse;
	} result_t;

	// classified work handed from front to back
	typedef struct packed {
		logic        refresh;
		logic [3:0]  row_drive;
		logic        key_valid;
		logic [3:0]  key_code;
		logic [15:0] word;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_slot_t;

	typedef enum logic [3:0] {
		PH_SCAN    = 4'b0001,
		PH_PRESS   = 4'b0010,
		PH_HELD    = 4'b0100,
		PH_RELEASE = 4'b1000
	} phase_t;

	localparam int unsigned QDEPTH  = 2;
	localparam int unsigned QPTR_W  = 1;
	localparam int unsigned QCNT_W  = 2;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
	localparam logic [3:0]  ALL_COLS_HIGH  = 4'hF;
	localparam logic [3:0]  LAST_BIT       = 4'd15;
	localparam logic [7:0]  BLANK_DIGIT    = 8'hFF;

	// common-anode segment patterns, active low
	function automatic logic [7:0] seg_code(input logic [3:0] key);
		logic [7:0] seg;
		case (key)
			4'h0: seg = 8'hC0;
			4'h1: seg = 8'hF9;
			4'h2: seg = 8'hA4;
			4'h3: seg = 8'hB0;
			4'h4: seg = 8'h99;
			4'h5: seg = 8'h92;
			4'h6: seg = 8'h82;
			4'h7: seg = 8'hF8;
			4'h8: seg = 8'h80;
			4'h9: seg = 8'h90;
			4'hA: seg = 8'h88;
			4'hB: seg = 8'h83;
			4'hC: seg = 8'hC6;
			4'hD: seg = 8'hA1;
			4'hE: seg = 8'h86;
			default: seg = 8'h8E;
		endcase
		return seg;
	endfunction

endpackage

`default_nettype wire

>>> design/kss_front.sv
`default_nettype none

module kss_front #(
	parameter int unsigned DIGITS = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire kss_pkg::item_t   item,
	input  wire logic             cfg_we,
	input  wire logic [15:0]      cfg_wdata,
	input  wire logic             q_full,
	output kss_pkg::cmd_slot_t    push
);

	localparam int unsigned IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGITS - 1);

	logic [15:0]         debounce_q;
	logic [7:0]          digits_q [DIGITS];
	logic [IDX_W-1:0]    refresh_digit_q;
	logic [1:0]          scan_row_q;
	kss_pkg::phase_t     phase_q;
	logic [1:0]          held_col_q;
	logic [15:0]         wait_q;

	logic                accept;
	logic [1:0]          row_n;
	kss_pkg::phase_t     phase_n;
	logic [1:0]          held_n;
	logic [15:0]         wait_n;
	logic                key_ok;
	logic [1:0]          low_col;
	logic                held_low;
	logic [3:0]          code;

	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;
	assign held_low   = !item.col_levels[held_col_q];
	assign code       = {scan_row_q, held_col_q};

	// lowest low column wins
	always_comb begin
		if (!item.col_levels[0]) begin
			low_col = 2'd0;
		end else if (!item.col_levels[1]) begin
			low_col = 2'd1;
		end else if (!item.col_levels[2]) begin
			low_col = 2'd2;
		end else begin
			low_col = 2'd3;
		end
	end

	// scan phase sequencing
	always_comb begin
		row_n   = scan_row_q;
		phase_n = phase_q;
		held_n  = held_col_q;
		wait_n  = wait_q;
		key_ok  = 1'b0;
		case (phase_q)
			kss_pkg::PH_SCAN: begin
				if (item.col_levels != kss_pkg::ALL_COLS_HIGH) begin
					held_n  = low_col;
					wait_n  = debounce_q;
					phase_n = kss_pkg::PH_PRESS;
				end else begin
					row_n = scan_row_q + 2'd1;
				end
			end
			kss_pkg::PH_PRESS: begin
				if (wait_q != 16'd0) begin
					wait_n = wait_q - 16'd1;
				end else if (held_low) begin
					key_ok  = 1'b1;
					phase_n = kss_pkg::PH_HELD;
				end else begin
					row_n   = scan_row_q + 2'd1;
					phase_n = kss_pkg::PH_SCAN;
				end
			end
			kss_pkg::PH_HELD: begin
				if (!held_low) begin
					wait_n  = debounce_q;
					phase_n = kss_pkg::PH_RELEASE;
				end
			end
			kss_pkg::PH_RELEASE: begin
				if (wait_q != 16'd0) begin
					wait_n = wait_q - 16'd1;
				end else begin
					row_n   = scan_row_q + 2'd1;
					phase_n = kss_pkg::PH_SCAN;
				end
			end
			default: begin
				row_n   = scan_row_q + 2'd1;
				phase_n = kss_pkg::PH_SCAN;
			end
		endcase
	end

	// classify into a command for the back end
	always_comb begin
		push.valid = accept;
		if (item.mode) begin
			push.cmd.refresh   = 1'b1;
			push.cmd.row_drive = ~(4'b0001 << scan_row_q);
			push.cmd.key_valid = 1'b0;
			push.cmd.key_code  = 4'd0;
			push.cmd.word      = {digits_q[refresh_digit_q], 8'd1 << refresh_digit_q};
		end else begin
			push.cmd.refresh   = 1'b0;
			push.cmd.row_drive = ~(4'b0001 << row_n);
			push.cmd.key_valid = key_ok;
			push.cmd.key_code  = key_ok ? code : 4'd0;
			push.cmd.word      = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= kss_pkg::DEBOUNCE_RESET;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_digit_q <= '0;
			scan_row_q      <= 2'd0;
			phase_q         <= kss_pkg::PH_SCAN;
			held_col_q      <= 2'd0;
			wait_q          <= 16'd0;
		end else if (accept) begin
			if (item.mode) begin
				refresh_digit_q <= (refresh_digit_q == LAST_IDX) ? '0
					: refresh_digit_q + IDX_W'(1);
			end else begin
				scan_row_q <= row_n;
				phase_q    <= phase_n;
				held_col_q <= held_n;
				wait_q     <= wait_n;
			end
		end
	end

	// digit buffer, newest in place zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				digits_q[i] <= kss_pkg::BLANK_DIGIT;
			end
		end else if (accept && !item.mode && key_ok) begin
			for (int i = DIGITS - 1; i >= 1; i--) begin
				digits_q[i] <= digits_q[i-1];
			end
			digits_q[0] <= kss_pkg::seg_code(code);
		end
	end

`ifndef SYNTHESIS
	a_press_entry: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !item.mode && phase_q == kss_pkg::PH_SCAN
			&& item.col_levels != kss_pkg::ALL_COLS_HIGH
		|=> phase_q == kss_pkg::PH_PRESS)
		else $error("press not latched into debounce");

	a_key_then_held: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && push.cmd.key_valid |=> phase_q == kss_pkg::PH_HELD)
		else $error("accepted key without moving to held");
`endif

endmodule

`default_nettype wire

>>> design/kss_queue.sv
`default_nettype none

module kss_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire kss_pkg::cmd_slot_t push,
	output logic                    full,
	input  wire logic               pop,
	output kss_pkg::cmd_slot_t      head
);

	kss_pkg::cmd_t               mem_q [kss_pkg::QDEPTH];
	logic [kss_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [kss_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [kss_pkg::QCNT_W-1:0]  count_q;
	logic                        do_push;
	logic                        do_pop;

	localparam logic [kss_pkg::QPTR_W-1:0] LAST_PTR = kss_pkg::QPTR_W'(kss_pkg::QDEPTH - 1);
	localparam logic [kss_pkg::QCNT_W-1:0] FULL_CNT = kss_pkg::QCNT_W'(kss_pkg::QDEPTH);

	assign full       = (count_q == FULL_CNT);
	assign head.valid = (count_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("command queue count out of range");
`endif

endmodule

`default_nettype wire

>>> design/kss_back.sv
`default_nettype none

module kss_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire kss_pkg::cmd_slot_t head,
	output logic                    pop,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output kss_pkg::result_t        result
);

	logic               result_valid_q;
	kss_pkg::result_t   result_q;
	logic [3:0]         bit_cnt_q;
	logic               load;
	logic               last_bit;
	kss_pkg::result_t   res_n;

	assign load     = head.valid && (!result_valid_q || !result_stall);
	assign last_bit = (bit_cnt_q == kss_pkg::LAST_BIT);
	assign pop      = load && (!head.cmd.refresh || last_bit);

	// refresh words go out msb first
	always_comb begin
		res_n.row_drive    = head.cmd.row_drive;
		res_n.key_valid    = head.cmd.key_valid;
		res_n.key_code     = head.cmd.key_code;
		res_n.serial_valid = head.cmd.refresh;
		res_n.serial_bit   = head.cmd.refresh && head.cmd.word[kss_pkg::LAST_BIT - bit_cnt_q];
		res_n.latch_pulse  = head.cmd.refresh && last_bit;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			bit_cnt_q      <= 4'd0;
		end else begin
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (load && head.cmd.refresh) begin
				bit_cnt_q <= last_bit ? 4'd0 : bit_cnt_q + 4'd1;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_latch_serial: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.latch_pulse |-> result.serial_valid && !result.key_valid)
		else $error("latch pulse on a non-serial result");

	a_mid_word: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q != 4'd0 |-> head.valid && head.cmd.refresh)
		else $error("serializer mid-word without a refresh command");
`endif

endmodule

`default_nettype wire

>>> design/keypad_scan_to_segment_display.sv
// keypad scanner and 8-digit display feeder. each input transaction is a tick: mode 0 is a
// keypad scan tick (col_levels are the sampled columns of the row currently driven) and
// gives one result transaction; mode 1 is a display refresh tick and gives sixteen result
// transactions, one serial bit each, msb first: segment byte of the current digit, then
// the one-hot digit select byte, with latch_pulse on the sixteenth. row_drive in every
// result is the row to drive from then on. the front end takes one tick per cycle while the
// queue is not full and resolves all scan and debounce state at once; a two-entry command
// queue sits between it and the serializer, and a result register follows. the serializer
// sends one bit per cycle unless the receiver stalls; a tick's first result is held in its
// queue entry and then in the result register. debounce_ticks is written through
// cfg_we / cfg_wdata (reset value 20) and should only change while the block is idle.
`default_nettype none

module keypad_scan_to_segment_display #(
	parameter int unsigned DIGITS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// tick transactions
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire kss_pkg::item_t    item,
	// result transactions
	output logic                   result_valid,
	input  wire logic              result_stall,
	output kss_pkg::result_t       result,
	// debounce_ticks register write
	input  wire logic              cfg_we,
	input  wire logic [15:0]       cfg_wdata
);

	// front end to queue, queue to back end
	kss_pkg::cmd_slot_t push;
	kss_pkg::cmd_slot_t head;
	logic               q_full;
	logic               pop;

	// scan state machine, digit buffer and refresh pointer; classifies each tick
	kss_front #(
		.DIGITS (DIGITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.q_full     (q_full),
		.push       (push)
	);

	// short command queue, lets the front keep taking ticks while bits shift out
	kss_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	// serializer and result register
	kss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

	// receiver hold-off long enough to back the block up into its input
	localparam int unsigned HOLD_OFF_CYCLES = 150;
	// cap on waiting for outstanding results before a register write or the end
	localparam int unsigned SETTLE_LIMIT    = 20000;
	// quiet cycles after the last result, to catch stray transactions
	localparam int unsigned DRAIN_CYCLES    = 20;
	// scan ticks allowed for the long press debounce
	localparam int unsigned LONG_PRESS_CAP  = 100;

	// tracks the keypad scanner and display buffer, and owes the result
	// transactions that each accepted tick produces
	class scan_display_mirror;
		logic [15:0]       debounce;
		logic [7:0]        digit_bytes [8];
		logic [7:0]        glyph [16];
		logic [2:0]        refresh_pos;
		logic [1:0]        row;
		kss_pkg::phase_t   phase;
		logic [1:0]        held_col;
		logic [15:0]       countdown;
		kss_pkg::result_t  awaited_outputs [$];
		int unsigned       mismatches;

		function new();
			glyph = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
				8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E};
			debounce = 16'd20;
			foreach (digit_bytes[i]) digit_bytes[i] = 8'hFF;
			refresh_pos = '0;
			row         = '0;
			phase       = kss_pkg::PH_SCAN;
			held_col    = '0;
			countdown   = '0;
			mismatches  = 0;
		endfunction

		function logic [3:0] row_lines();
			return ~(4'b0001 << row);
		endfunction

		function void next_row();
			row   = row + 2'd1;
			phase = kss_pkg::PH_SCAN;
		endfunction

		function void take_tick(kss_pkg::item_t t);
			kss_pkg::result_t r;
			logic [15:0]      word;
			logic             held_low;
			logic [1:0]       c;
			int               k;
			int               j;
			r = '0;
			if (t.mode) begin
				// segment byte then one-hot digit select, msb first
				word = {digit_bytes[refresh_pos], 8'b1 << refresh_pos};
				for (k = 0; k < 16; k++) begin
					r.row_drive    = row_lines();
					r.serial_valid = 1'b1;
					r.serial_bit   = word[15 - k];
					r.latch_pulse  = (k == 15);
					awaited_outputs.push_back(r);
				end
				refresh_pos = refresh_pos + 3'd1;
				return;
			end
			held_low = !t.col_levels[held_col];
			case (phase)
				kss_pkg::PH_SCAN: begin
					if (t.col_levels != 4'hF) begin
						// lowest low column wins
						c = 2'd0;
						while (c < 2'd3 && t.col_levels[c]) c = c + 2'd1;
						held_col  = c;
						countdown = debounce;
						phase     = kss_pkg::PH_PRESS;
					end else begin
						next_row();
					end
				end
				kss_pkg::PH_PRESS: begin
					if (countdown != 16'd0) begin
						countdown = countdown - 16'd1;
					end else if (held_low) begin
						r.key_valid = 1'b1;
						r.key_code  = {row, held_col};
						for (j = 7; j > 0; j--) digit_bytes[j] = digit_bytes[j - 1];
						digit_bytes[0] = glyph[{row, held_col}];
						phase = kss_pkg::PH_HELD;
					end else begin
						next_row();
					end
				end
				kss_pkg::PH_HELD: begin
					if (!held_low) begin
						countdown = debounce;
						phase     = kss_pkg::PH_RELEASE;
					end
				end
				default: begin
					if (countdown != 16'd0) begin
						countdown = countdown - 16'd1;
					end else begin
						next_row();
					end
				end
			endcase
			r.row_drive = row_lines();
			awaited_outputs.push_back(r);
		endfunction

		function void compare(string field, logic [3:0] want, logic [3:0] got);
			if (got !== want) begin
				$error("%s: expected %h, got %h", field, want, got);
				mismatches++;
			end
		endfunction

		function void match_output(kss_pkg::result_t got);
			kss_pkg::result_t want;
			if (awaited_outputs.size() == 0) begin
				$error("result transaction with nothing awaited: %h", got);
				mismatches++;
				return;
			end
			want = awaited_outputs.pop_front();
			compare("row_drive", want.row_drive, got.row_drive);
			compare("key_valid", want.key_valid, got.key_valid);
			compare("key_code", want.key_code, got.key_code);
			compare("serial_valid", want.serial_valid, got.serial_valid);
			compare("serial_bit", want.serial_bit, got.serial_bit);
			compare("latch_pulse", want.latch_pulse, got.latch_pulse);
		endfunction
	endclass

	logic             clk;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_stall;
	kss_pkg::item_t   item         = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	kss_pkg::result_t result;
	logic             cfg_we       = 1'b0;
	logic [15:0]      cfg_wdata    = '0;

	// idling switches, set by the stimulus process (the receiver clears hold_off_req)
	bit send_gaps    = 1'b0;
	bit recv_gaps    = 1'b0;
	bit hold_off_req = 1'b0;
	bit stuck        = 1'b0;

	scan_display_mirror mirror = new();

	keypad_scan_to_segment_display #(.DIGITS(8)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// generous fixed limit on the whole run
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	// result side: every accepted transaction is checked against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) mirror.match_output(result);
	end

	// receiver stall: random bursts, plus one long hold-off on request
	initial begin : receiver
		int unsigned n;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				result_stall <= 1'b1;
				for (n = 0; n < HOLD_OFF_CYCLES; n++) @(negedge clk);
				result_stall <= 1'b0;
				hold_off_req = 1'b0;
			end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// offer one tick transaction, optionally after an idle burst, and wait until taken;
	// entered and left at a falling edge so valid stays up between back-to-back ticks
	task automatic send_tick(input kss_pkg::item_t t);
		if (send_gaps && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		item       <= t;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		mirror.take_tick(t);
		@(negedge clk);
	endtask

	task automatic scan(input logic [3:0] cols);
		kss_pkg::item_t t;
		t.mode       = 1'b0;
		t.col_levels = cols;
		send_tick(t);
	endtask

	// refresh ticks carry junk on the column lines, which must be ignored
	task automatic refresh();
		kss_pkg::item_t t;
		t.mode       = 1'b1;
		t.col_levels = 4'($urandom_range(0, 15));
		send_tick(t);
	endtask

	// drop valid and wait for every owed result, marking the run stuck if they do not all come
	task automatic settle();
		int unsigned waited;
		item_valid <= 1'b0;
		waited = 0;
		while (mirror.awaited_outputs.size() != 0 && waited < SETTLE_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (mirror.awaited_outputs.size() != 0) stuck = 1'b1;
		repeat (4) @(negedge clk);
	endtask

	task automatic write_debounce(input logic [15:0] ticks);
		cfg_we    <= 1'b1;
		cfg_wdata <= ticks;
		@(negedge clk);
		cfg_we <= 1'b0;
		mirror.debounce = ticks;
	endtask

	// steer the column lines by the tracked scan phase so that most presses run
	// through debounce, hold and release, with broken presses mixed in
	function automatic kss_pkg::item_t pick_tick();
		kss_pkg::item_t t;
		t.mode       = ($urandom_range(0, 4) == 0);
		t.col_levels = 4'($urandom_range(0, 15));
		if (!t.mode) begin
			case (mirror.phase)
				kss_pkg::PH_SCAN: begin
					if ($urandom_range(0, 3) == 0) t.col_levels = 4'hF;
				end
				kss_pkg::PH_PRESS: begin
					t.col_levels[mirror.held_col] = ($urandom_range(0, 7) == 0);
				end
				kss_pkg::PH_HELD: begin
					t.col_levels[mirror.held_col] = ($urandom_range(0, 3) == 0);
				end
				default: begin
				end
			endcase
		end
		return t;
	endfunction

	task automatic random_ticks(input int unsigned count);
		int unsigned n;
		for (n = 0; n < count; n++) send_tick(pick_tick());
	endtask

	initial begin : stimulus
		int unsigned n;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// refresh straight out of reset: digit 0 blank, select byte 0x01
		refresh();
		settle();

		// zero debounce: re-check and release advance on the very next tick
		write_debounce(16'd0);
		scan(4'b1111);      // no key, row 0 -> 1
		scan(4'b0000);      // all columns low, column 0 taken
		scan(4'b0000);      // confirmed, key 4
		scan(4'b1110);      // held, other columns wander
		refresh();          // refresh while waiting for release
		scan(4'b1111);      // release seen
		scan(4'b0000);      // release debounce over, columns ignored, row 1 -> 2
		scan(4'b0111);      // only column 3 low
		scan(4'b0111);      // confirmed, key 11
		scan(4'b1111);
		scan(4'b1111);      // row 2 -> 3
		scan(4'b1101);      // column 1 low
		scan(4'b1111);      // gone at re-check: no key, row 3 -> 0
		scan(4'b1011);
		scan(4'b1011);      // confirmed, key 2
		scan(4'b1111);
		scan(4'b1111);      // row 0 -> 1
		for (n = 0; n < 7; n++) refresh();  // digit select wraps past 7
		settle();

		// long debounce: one press counted all the way down
		write_debounce(16'd30);
		n = 0;
		while (mirror.phase != kss_pkg::PH_HELD && n < LONG_PRESS_CAP) begin
			scan({3'($urandom_range(0, 7)), 1'b0});
			n++;
		end
		settle();

		// random traffic under several settings, idling on both sides
		write_debounce(16'd1);
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		random_ticks(80);
		settle();

		// receiver holds off while ticks keep coming, so the input backs up
		write_debounce(16'd3);
		hold_off_req = 1'b1;
		random_ticks(80);
		settle();

		write_debounce(16'd20);
		random_ticks(60);
		settle();

		// last stretch at full rate, no idling anywhere
		write_debounce(16'd2);
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		random_ticks(90);
		settle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.mismatches == 0 && !stuck && mirror.awaited_outputs.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
design/kss_pkg.sv
design/kss_front.sv
design/kss_queue.sv
design/kss_back.sv
design/keypad_scan_to_segment_display.sv
tb/sv/tb.sv
